// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // Table capacity and the widths that follow from it.
  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

  // Field widths.
  localparam int unsigned ID_W    = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned BURST_W = 10;
  localparam int unsigned PRIO_W  = 14;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // One process table entry as it is held in the table memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/core/preemptive_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Preemptive priority scheduler over a table of up to pps_pkg::MAX_PROCS processes.
// A load command (cmd_i low) appends an entry; busy_o stays low.
// A tick command (cmd_i high) keeps busy_o high while the table memory is
// read one entry per cycle to find the ready entry with the smallest
// priority; then the chosen entry is written back with one less unit of
// remaining work. The tick's result is presented in the same cycle that
// busy_o falls, for exactly one cycle, marked by valid_o. The receiver cannot
// stall, so it must take every result transfer as it appears. Loads never
// produce a result. Loads beyond capacity are dropped and time saturates.

module preemptive_priority_scheduler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         cmd_i,
  input  wire logic [pps_pkg::ID_W-1:0]     proc_id_i,
  input  wire logic [pps_pkg::TIME_W-1:0]   arrival_i,
  input  wire logic [pps_pkg::BURST_W-1:0]  burst_i,
  input  wire logic [pps_pkg::PRIO_W-1:0]   prio_i,
  output logic                              valid_o,
  output logic                              ran_valid_o,
  output logic      [pps_pkg::ID_W-1:0]     ran_id_o,
  output logic                              finished_o,
  output logic      [pps_pkg::TIME_W-1:0]   completion_time_o,
  output logic      [pps_pkg::TIME_W-1:0]   turnaround_o,
  output logic      [pps_pkg::TIME_W-1:0]   waiting_o,
  output logic                              all_done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e                       state_q, state_d;
  logic [pps_pkg::CNT_W-1:0]    loaded_q, loaded_d;
  logic [pps_pkg::CNT_W-1:0]    done_q, done_d;
  logic [pps_pkg::TIME_W-1:0]   now_q, now_d;
  logic [pps_pkg::CNT_W-1:0]    iss_q, iss_d;
  logic                         pend_q, pend_d;
  logic [pps_pkg::IDX_W-1:0]    chk_q, chk_d;
  logic                         found_q, found_d;
  logic [pps_pkg::IDX_W-1:0]    sel_q, sel_d;
  pps_pkg::entry_t              best_q, best_d;

  logic                         valid_d, ran_valid_d, finished_d, all_done_d;
  logic [pps_pkg::ID_W-1:0]     ran_id_d;
  logic [pps_pkg::TIME_W-1:0]   ct_d, tt_d, wt_d;

  logic                         ram_we;
  logic [pps_pkg::IDX_W-1:0]    ram_waddr;
  pps_pkg::entry_t              ram_wdata;
  logic [pps_pkg::IDX_W-1:0]    ram_raddr;
  pps_pkg::entry_t              ram_rdata;

  logic                         accept;
  logic                         ready_entry;
  logic [pps_pkg::BURST_W-1:0]  rem_new;
  logic [pps_pkg::TIME_W-1:0]   tt_full;

  assign accept = start_i && !busy_o;

  // Process table memory.
  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (pps_pkg::MAX_PROCS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An entry read back during the scan competes if it has work and has arrived.
  assign ready_entry = (ram_rdata.remaining != '0) && (ram_rdata.arrival <= now_q);

  // Finish arithmetic on the chosen entry, against the advanced time.
  assign rem_new = best_q.remaining - 1'b1;
  assign tt_full = now_d - best_q.arrival;

  // Next-state logic for the scheduler.
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    done_d      = done_q;
    now_d       = now_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    chk_d       = iss_q[pps_pkg::IDX_W-1:0];
    found_d     = found_q;
    sel_d       = sel_q;
    best_d      = best_q;
    valid_d     = 1'b0;
    ran_valid_d = 1'b0;
    ran_id_d    = '0;
    finished_d  = 1'b0;
    ct_d        = '0;
    tt_d        = '0;
    wt_d        = '0;
    all_done_d  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = loaded_q[pps_pkg::IDX_W-1:0];
    ram_raddr   = iss_q[pps_pkg::IDX_W-1:0];
    ram_wdata.id        = proc_id_i;
    ram_wdata.arrival   = arrival_i;
    ram_wdata.burst     = burst_i;
    ram_wdata.prio      = prio_i;
    ram_wdata.remaining = burst_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == pps_pkg::CMD_LOAD) begin
            // Append the entry unless the table is full.
            if (loaded_q < pps_pkg::CNT_W'(pps_pkg::MAX_PROCS)) begin
              ram_we   = 1'b1;
              loaded_d = loaded_q + 1'b1;
              if (burst_i == '0) begin
                done_d = done_q + 1'b1;
              end
            end
          end else begin
            iss_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Compare the entry whose read returns this cycle.
        if (pend_q && ready_entry && (!found_q || (ram_rdata.prio < best_q.prio))) begin
          found_d = 1'b1;
          sel_d   = chk_q;
          best_d  = ram_rdata;
        end
        // Issue the next read, or finish once every entry has been asked for.
        if (iss_q != loaded_q) begin
          pend_d = 1'b1;
          iss_d  = iss_q + 1'b1;
        end else begin
          state_d = S_UPDATE;
        end
      end

      S_UPDATE: begin
        if (now_q != pps_pkg::TIME_MAX) begin
          now_d = now_q + 1'b1;
        end
        valid_d = 1'b1;
        if (found_q) begin
          ran_valid_d = 1'b1;
          ran_id_d    = best_q.id;
          // Write the chosen entry back with one less unit of work.
          ram_we              = 1'b1;
          ram_waddr           = sel_q;
          ram_wdata           = best_q;
          ram_wdata.remaining = rem_new;
          if (rem_new == '0) begin
            finished_d = 1'b1;
            done_d     = done_q + 1'b1;
            ct_d       = now_d;
            tt_d       = tt_full;
            wt_d       = (tt_full >= pps_pkg::TIME_W'(best_q.burst))
                         ? tt_full - pps_pkg::TIME_W'(best_q.burst) : '0;
          end
        end
        all_done_d = (done_d == loaded_q);
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      busy_o            <= 1'b0;
      loaded_q          <= '0;
      done_q            <= '0;
      now_q             <= '0;
      iss_q             <= '0;
      pend_q            <= 1'b0;
      chk_q             <= '0;
      found_q           <= 1'b0;
      sel_q             <= '0;
      best_q            <= '0;
      valid_o           <= 1'b0;
      ran_valid_o       <= 1'b0;
      ran_id_o          <= '0;
      finished_o        <= 1'b0;
      completion_time_o <= '0;
      turnaround_o      <= '0;
      waiting_o         <= '0;
      all_done_o        <= 1'b0;
    end else begin
      state_q           <= state_d;
      busy_o            <= (state_d != S_IDLE);
      loaded_q          <= loaded_d;
      done_q            <= done_d;
      now_q             <= now_d;
      iss_q             <= iss_d;
      pend_q            <= pend_d;
      chk_q             <= chk_d;
      found_q           <= found_d;
      sel_q             <= sel_d;
      best_q            <= best_d;
      valid_o           <= valid_d;
      ran_valid_o       <= ran_valid_d;
      ran_id_o          <= ran_id_d;
      finished_o        <= finished_d;
      completion_time_o <= ct_d;
      turnaround_o      <= tt_d;
      waiting_o         <= wt_d;
      all_done_o        <= all_done_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== dv/tb_preemptive_priority_scheduler_core.sv =====
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_core;

  // Longest stretch without any transfer before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned RAND_ITEMS  = 600;

  // One tick outcome as the block reports it.
  typedef struct packed {
    logic                        ran_valid;
    logic [pps_pkg::ID_W-1:0]    ran_id;
    logic                        finished;
    logic [pps_pkg::TIME_W-1:0]  completion;
    logic [pps_pkg::TIME_W-1:0]  turnaround;
    logic [pps_pkg::TIME_W-1:0]  waiting;
    logic                        all_done;
  } tick_result_t;

  // Process table model plus the queue of tick outcomes still to be seen.
  class sched_scoreboard;
    logic [pps_pkg::ID_W-1:0]    tab_id        [pps_pkg::MAX_PROCS];
    logic [pps_pkg::TIME_W-1:0]  tab_arrival   [pps_pkg::MAX_PROCS];
    logic [pps_pkg::BURST_W-1:0] tab_burst     [pps_pkg::MAX_PROCS];
    logic [pps_pkg::PRIO_W-1:0]  tab_prio      [pps_pkg::MAX_PROCS];
    logic [pps_pkg::BURST_W-1:0] tab_remaining [pps_pkg::MAX_PROCS];
    int unsigned                 loaded;
    int unsigned                 done_cnt;
    logic [pps_pkg::TIME_W-1:0]  now;
    tick_result_t                pending_ticks[$];
    int unsigned                 errors;

    function new();
      loaded   = 0;
      done_cnt = 0;
      now      = '0;
      errors   = 0;
    endfunction

    // Apply one accepted command; a tick queues the outcome it must produce.
    function void note_item(logic cmd, logic [pps_pkg::ID_W-1:0] id,
                            logic [pps_pkg::TIME_W-1:0] arrival,
                            logic [pps_pkg::BURST_W-1:0] burst,
                            logic [pps_pkg::PRIO_W-1:0] prio);
      tick_result_t                res;
      bit                          found;
      int unsigned                 sel;
      logic [pps_pkg::TIME_W-1:0]  tt;
      res   = '0;
      found = 1'b0;
      sel   = 0;
      if (cmd == pps_pkg::CMD_LOAD) begin
        // Loads past capacity are dropped; a zero burst counts as done at once.
        if (loaded < pps_pkg::MAX_PROCS) begin
          tab_id[loaded]        = id;
          tab_arrival[loaded]   = arrival;
          tab_burst[loaded]     = burst;
          tab_prio[loaded]      = prio;
          tab_remaining[loaded] = burst;
          if (burst == '0) done_cnt++;
          loaded++;
        end
        return;
      end
      // Pick the ready entry with the smallest priority, earliest on a tie.
      for (int unsigned i = 0; i < loaded; i++) begin
        if (tab_remaining[i] != '0 && tab_arrival[i] <= now &&
            (!found || tab_prio[i] < tab_prio[sel])) begin
          found = 1'b1;
          sel   = i;
        end
      end
      if (now != pps_pkg::TIME_MAX) now++;
      if (found) begin
        res.ran_valid = 1'b1;
        res.ran_id    = tab_id[sel];
        tab_remaining[sel]--;
        if (tab_remaining[sel] == '0) begin
          done_cnt++;
          tt             = now - tab_arrival[sel];
          res.finished   = 1'b1;
          res.completion = now;
          res.turnaround = tt;
          // Once time has saturated the waiting time can go negative; it floors at zero.
          res.waiting    = (tt >= pps_pkg::TIME_W'(tab_burst[sel]))
                           ? tt - pps_pkg::TIME_W'(tab_burst[sel]) : '0;
        end
      end
      res.all_done = (done_cnt == loaded);
      pending_ticks.push_back(res);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%04h, expected 0x%04h", name, got, want));
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (pending_ticks.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
        return;
      end
      want = pending_ticks.pop_front();
      compare_field("ran_valid", 16'(got.ran_valid), 16'(want.ran_valid));
      compare_field("ran_id", got.ran_id, want.ran_id);
      compare_field("finished", 16'(got.finished), 16'(want.finished));
      compare_field("completion_time", got.completion, want.completion);
      compare_field("turnaround", got.turnaround, want.turnaround);
      compare_field("waiting", got.waiting, want.waiting);
      compare_field("all_done", 16'(got.all_done), 16'(want.all_done));
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic                         cmd_i;
  logic [pps_pkg::ID_W-1:0]     proc_id_i;
  logic [pps_pkg::TIME_W-1:0]   arrival_i;
  logic [pps_pkg::BURST_W-1:0]  burst_i;
  logic [pps_pkg::PRIO_W-1:0]   prio_i;
  logic                         valid_o;
  logic                         ran_valid_o;
  logic [pps_pkg::ID_W-1:0]     ran_id_o;
  logic                         finished_o;
  logic [pps_pkg::TIME_W-1:0]   completion_time_o;
  logic [pps_pkg::TIME_W-1:0]   turnaround_o;
  logic [pps_pkg::TIME_W-1:0]   waiting_o;
  logic                         all_done_o;

  sched_scoreboard              sb;
  int unsigned                  quiet_cycles;

  preemptive_priority_scheduler_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .cmd_i             (cmd_i),
    .proc_id_i         (proc_id_i),
    .arrival_i         (arrival_i),
    .burst_i           (burst_i),
    .prio_i            (prio_i),
    .valid_o           (valid_o),
    .ran_valid_o       (ran_valid_o),
    .ran_id_o          (ran_id_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o),
    .all_done_o        (all_done_o)
  );

  always #2 clk_i = ~clk_i;

  // Present one command after a random gap and hold it until the transfer.
  task automatic drive_item(logic cmd, logic [pps_pkg::ID_W-1:0] id,
                            logic [pps_pkg::TIME_W-1:0] arrival,
                            logic [pps_pkg::BURST_W-1:0] burst,
                            logic [pps_pkg::PRIO_W-1:0] prio,
                            int unsigned idle_pct);
    @(negedge clk_i);
    for (int unsigned g = 0; g < MAX_GAP && $urandom_range(99) < idle_pct; g++) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i   <= 1'b1;
    cmd_i     <= cmd;
    proc_id_i <= id;
    arrival_i <= arrival;
    burst_i   <= burst;
    prio_i    <= prio;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(cmd, id, arrival, burst, prio);
  endtask

  // A tick with junk in the load fields, which the block must ignore.
  task automatic drive_tick(int unsigned idle_pct);
    drive_item(pps_pkg::CMD_TICK, pps_pkg::ID_W'($urandom), pps_pkg::TIME_W'($urandom),
               pps_pkg::BURST_W'($urandom), pps_pkg::PRIO_W'($urandom), idle_pct);
  endtask

  // Every result transfer is checked against the oldest outstanding tick.
  always @(posedge clk_i) begin : result_monitor
    tick_result_t seen;
    if (rst_ni && valid_o) begin
      seen.ran_valid  = ran_valid_o;
      seen.ran_id     = ran_id_o;
      seen.finished   = finished_o;
      seen.completion = completion_time_o;
      seen.turnaround = turnaround_o;
      seen.waiting    = waiting_o;
      seen.all_done   = all_done_o;
      sb.check_result(seen);
    end
  end

  // Hang detection: count cycles in which neither side makes a transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned                 n_items;
    int unsigned                 idle_pct;
    int unsigned                 pick;
    logic [pps_pkg::TIME_W-1:0]  arr;
    logic [pps_pkg::BURST_W-1:0] bst;
    logic [pps_pkg::PRIO_W-1:0]  pri;

    sb           = new();
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    cmd_i        = pps_pkg::CMD_LOAD;
    proc_id_i    = '0;
    arrival_i    = '0;
    burst_i      = '0;
    prio_i       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, zero burst, ties, preemption, out-of-range
    // priority, a late load with a past arrival and a job that only arrives
    // once time has saturated.
    drive_tick(0);
    drive_item(pps_pkg::CMD_LOAD, 16'hFFFF, 16'd0, 10'd3, 14'd9999, 0);
    drive_item(pps_pkg::CMD_LOAD, 16'h0000, 16'd0, 10'd0, 14'd0, 0);
    drive_tick(0);
    drive_item(pps_pkg::CMD_LOAD, 16'h1111, 16'd1, 10'd2, 14'h3FFF, 0);
    drive_item(pps_pkg::CMD_LOAD, 16'h2222, 16'd0, 10'd2, 14'd5, 0);
    drive_item(pps_pkg::CMD_LOAD, 16'h3333, 16'd0, 10'd2, 14'd5, 0);
    drive_item(pps_pkg::CMD_LOAD, 16'hAAAA, pps_pkg::TIME_MAX, 10'h3FF, 14'd0, 0);
    repeat (8) drive_tick(0);
    drive_item(pps_pkg::CMD_LOAD, 16'h5555, 16'd0, 10'd1, 14'h3FFF, 0);
    drive_tick(0);
    drive_tick(0);

    // Random mix: mostly ticks, with loads spread out so the table fills
    // gradually; loads after it is full are noise that the block drops.
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      if (n_items < 150) idle_pct = 0;
      else if (n_items < 300) idle_pct = 73;
      else if (n_items < 450) idle_pct = 26;
      else idle_pct = 0;
      if ($urandom_range(99) < 8) begin
        pick = $urandom_range(99);
        if (pick < 60) arr = sb.now + pps_pkg::TIME_W'($urandom_range(24)) - 16'd4;
        else if (pick < 80) arr = pps_pkg::TIME_W'($urandom);
        else if (pick < 87) arr = '0;
        else if (pick < 94) arr = pps_pkg::TIME_MAX;
        else arr = sb.now;
        pick = $urandom_range(99);
        if (pick < 70) bst = pps_pkg::BURST_W'($urandom_range(1, 12));
        else if (pick < 80) bst = '0;
        else if (pick < 90) bst = '1;
        else bst = pps_pkg::BURST_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) pri = pps_pkg::PRIO_W'($urandom_range(7));
        else if (pick < 75) pri = pps_pkg::PRIO_W'($urandom_range(9999));
        else pri = pps_pkg::PRIO_W'($urandom);
        if (sb.loaded < pps_pkg::MAX_PROCS) n_items++;
        drive_item(pps_pkg::CMD_LOAD, pps_pkg::ID_W'($urandom), arr, bst, pri, idle_pct);
      end else begin
        n_items++;
        drive_tick(idle_pct);
      end
    end

    // A few closing ticks.
    repeat (3) drive_tick(0);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending_ticks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
